// File: hdl/scrolling_sixteen_segment_driver_assert.svh
// Assertion macros for the scrolling sixteen-segment display driver.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef SCROLLING_SIXTEEN_SEGMENT_DRIVER_ASSERT_SVH
`define SCROLLING_SIXTEEN_SEGMENT_DRIVER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/ssd_pkg.sv
// Package for the scrolling sixteen-segment display driver.
// Holds request modes, register indexes, character constants and the font.
// No dependencies.
package ssd_pkg;

    typedef enum logic [1:0] {
        MODE_REFRESH = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SCROLL  = 2'd2,
        MODE_CLEAR   = 2'd3
    } mode_t;

    localparam logic [1:0] CFG_CURSOR_POS  = 2'd0;
    localparam logic [1:0] CFG_CURSOR_CHAR = 2'd1;

    localparam int unsigned CHAR_W = 7;
    localparam int unsigned SEG_W  = 16;

    localparam logic [CHAR_W-1:0] SPACE_CODE       = 7'd32;
    localparam logic [CHAR_W-1:0] CURSOR_CHAR_INIT = 7'd95;
    localparam logic [SEG_W-1:0]  BLANK_PATTERN    = 16'hFFFF;

    function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [SEG_W-1:0] pat;
        pat = 16'h0000;
        case (code[5:0] ^ 6'h20)
            6'd0:    pat = 16'hFFFF;
            6'd13:   pat = 16'hFF3F;
            6'd16:   pat = 16'h00F6;
            6'd17:   pat = 16'hCFF7;
            6'd18:   pat = 16'h113F;
            6'd19:   pat = 16'h03BF;
            6'd20:   pat = 16'hCE3F;
            6'd21:   pat = 16'h223F;
            6'd22:   pat = 16'h203F;
            6'd23:   pat = 16'h3F36;
            6'd24:   pat = 16'h003F;
            6'd25:   pat = 16'h023F;
            6'd30:   pat = 16'hFFDE;
            6'd33:   pat = 16'h0C3F;
            6'd34:   pat = 16'h03AD;
            6'd35:   pat = 16'h30FF;
            6'd36:   pat = 16'h03ED;
            6'd37:   pat = 16'h307F;
            6'd38:   pat = 16'h3C7F;
            6'd39:   pat = 16'h20BF;
            6'd40:   pat = 16'hCC3F;
            6'd41:   pat = 16'h33ED;
            6'd42:   pat = 16'hC1FF;
            6'd43:   pat = 16'hFC73;
            6'd44:   pat = 16'hF0FF;
            6'd45:   pat = 16'hCCD7;
            6'd46:   pat = 16'hCCDB;
            6'd47:   pat = 16'h00FF;
            6'd48:   pat = 16'h1C3F;
            6'd49:   pat = 16'h00FB;
            6'd50:   pat = 16'h1C3B;
            6'd51:   pat = 16'h223F;
            6'd52:   pat = 16'h3FED;
            6'd53:   pat = 16'hC0FF;
            6'd54:   pat = 16'hFCF6;
            6'd55:   pat = 16'hCCFA;
            6'd56:   pat = 16'hFFD2;
            6'd57:   pat = 16'hFFD5;
            6'd58:   pat = 16'h33F6;
            6'd63:   pat = 16'hF3FF;
            default: pat = 16'h0000;
        endcase
        if (code[6] == code[5])
        begin
            pat = BLANK_PATTERN;
        end
        return pat;
    endfunction

endpackage

// File: hdl/scrolling_sixteen_segment_driver.sv
// Scrolling sixteen-segment display driver: message store, scroll window and digit mux.
// Depends on ssd_pkg and scrolling_sixteen_segment_driver_assert.svh.
// Refresh, append and clear requests complete without blocking the input; a refresh result
// is registered and valid in the cycle after the request. A new request is taken every
// cycle while no scroll step is busy and the output is not stalled. A scroll step reads the
// store once per digit through its single read port and blocks the input until it is done.
`include "scrolling_sixteen_segment_driver_assert.svh"

module scrolling_sixteen_segment_driver #(
    parameter int unsigned MSG_DEPTH  = 128,
    parameter int unsigned NUM_DIGITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // char_code
    input  logic [1:0]                       s_tuser,   // mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // segments
    output logic [$clog2(NUM_DIGITS)-1:0]    m_tuser,   // digit_select
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [6:0]                       cfg_data
);

    // Reset is asynchronous and active low; the message store itself is not cleared.
    localparam int unsigned ADDR_W = $clog2(MSG_DEPTH);
    localparam int unsigned LEN_W  = $clog2(MSG_DEPTH + 1);
    localparam int unsigned DIG_W  = $clog2(NUM_DIGITS);
    localparam int unsigned CUR_W  = $clog2(NUM_DIGITS + 1);
    localparam int unsigned STEP_W = $clog2(NUM_DIGITS + 1);
    localparam int unsigned CW     = ssd_pkg::CHAR_W;

    logic [CW-1:0]     msg_mem [MSG_DEPTH];
    logic [CW-1:0]     rd_data_reg;

    logic [CUR_W-1:0]  cursor_pos_reg;
    logic [CW-1:0]     cursor_char_reg;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [CW-1:0]     window_reg [NUM_DIGITS];
    logic [CW-1:0]     window_next [NUM_DIGITS];
    logic [DIG_W-1:0]  dig_reg, dig_next;
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pend_reg, pend_next;
    logic              pend_space_reg, pend_space_next;
    logic [DIG_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [15:0]       seg_reg, seg_next;
    logic [DIG_W-1:0]  sel_reg, sel_next;

    logic              accept;
    logic              issue;
    logic              do_append;
    ssd_pkg::mode_t    mode;
    logic [CW-1:0]     char_code;
    logic [CW-1:0]     shown;

    assign mode      = ssd_pkg::mode_t'(s_tuser);
    assign char_code = s_tdata[CW-1:0];
    assign s_tready  = !busy_reg && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign issue     = busy_reg && (step_reg != STEP_W'(NUM_DIGITS));
    assign do_append = accept && (mode == ssd_pkg::MODE_APPEND)
                       && (length_reg != LEN_W'(MSG_DEPTH));
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = seg_reg;
    assign m_tuser   = sel_reg;

    assign shown = (cursor_pos_reg == CUR_W'(dig_reg)) ? cursor_char_reg
                                                        : window_reg[dig_reg];

    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            msg_mem[length_reg[ADDR_W-1:0]] <= char_code;
        end
        if (issue)
        begin
            rd_data_reg <= msg_mem[ptr_reg];
        end
    end

    always_comb
    begin
        length_next     = length_reg;
        offset_next     = offset_reg;
        ptr_next        = ptr_reg;
        window_next     = window_reg;
        dig_next        = dig_reg;
        busy_next       = busy_reg;
        step_next       = step_reg;
        pend_next       = 1'b0;
        pend_space_next = pend_space_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        seg_next        = seg_reg;
        sel_next        = sel_reg;

        if (pend_reg)
        begin
            window_next[pend_idx_reg] = pend_space_reg ? ssd_pkg::SPACE_CODE : rd_data_reg;
        end

        if (issue)
        begin
            pend_next       = 1'b1;
            pend_idx_next   = step_reg[DIG_W-1:0];
            pend_space_next = LEN_W'(step_reg) >= length_reg;
            step_next       = step_reg + STEP_W'(1);
            ptr_next        = (LEN_W'(ptr_reg) + LEN_W'(1) == length_reg)
                              ? '0 : ptr_reg + ADDR_W'(1);
        end
        else if (busy_reg && pend_reg)
        begin
            busy_next = 1'b0;
        end

        if (accept)
        begin
            case (mode)
                ssd_pkg::MODE_REFRESH:
                begin
                    out_valid_next = 1'b1;
                    sel_next       = dig_reg;
                    seg_next       = ssd_pkg::glyph_of(shown);
                    dig_next       = (dig_reg == DIG_W'(NUM_DIGITS - 1))
                                     ? '0 : dig_reg + DIG_W'(1);
                end
                ssd_pkg::MODE_APPEND:
                begin
                    if (do_append)
                    begin
                        length_next = length_reg + LEN_W'(1);
                    end
                end
                ssd_pkg::MODE_SCROLL:
                begin
                    if (length_reg == '0)
                    begin
                        offset_next = '0;
                        for (int i = 0; i < NUM_DIGITS; i++)
                        begin
                            window_next[i] = ssd_pkg::SPACE_CODE;
                        end
                    end
                    else
                    begin
                        busy_next   = 1'b1;
                        step_next   = '0;
                        ptr_next    = offset_reg;
                        offset_next = (LEN_W'(offset_reg) + LEN_W'(1) == length_reg)
                                      ? '0 : offset_reg + ADDR_W'(1);
                    end
                end
                ssd_pkg::MODE_CLEAR:
                begin
                    length_next = '0;
                    offset_next = '0;
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        window_next[i] = ssd_pkg::SPACE_CODE;
                    end
                end
                default:
                begin
                    length_next = length_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_pos_reg  <= CUR_W'(NUM_DIGITS);
            cursor_char_reg <= ssd_pkg::CURSOR_CHAR_INIT;
            length_reg      <= '0;
            offset_reg      <= '0;
            dig_reg         <= '0;
            busy_reg        <= 1'b0;
            step_reg        <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                window_reg[i] <= ssd_pkg::SPACE_CODE;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ssd_pkg::CFG_CURSOR_POS)
                begin
                    cursor_pos_reg <= cfg_data[CUR_W-1:0];
                end
                else if (cfg_index == ssd_pkg::CFG_CURSOR_CHAR)
                begin
                    cursor_char_reg <= cfg_data;
                end
            end
            length_reg    <= length_next;
            offset_reg    <= offset_next;
            dig_reg       <= dig_next;
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            window_reg    <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pend_space_reg <= pend_space_next;
        pend_idx_reg   <= pend_idx_next;
        seg_reg        <= seg_next;
        sel_reg        <= sel_next;
    end

    `SSD_ASSERT_IMP(a_busy_blocks_input, clk, rst_n, busy_reg, !s_tready)
    `SSD_ASSERT_IMP(a_digit_in_range, clk, rst_n, 1'b1, dig_reg < DIG_W'(NUM_DIGITS))
    `SSD_ASSERT_IMP(a_length_in_range, clk, rst_n, 1'b1, length_reg <= LEN_W'(MSG_DEPTH))
    `SSD_ASSERT_NEXT(a_scroll_starts, clk, rst_n,
        accept && (mode == ssd_pkg::MODE_SCROLL) && (length_reg != '0), busy_reg)
    `SSD_ASSERT_IMP(a_offset_below_length, clk, rst_n, busy_reg,
        LEN_W'(offset_reg) < length_reg)

endmodule

// File: tb/tb_scrolling_sixteen_segment_driver.sv
// Testbench for the scrolling sixteen-segment display driver: directed table, then random
// phases with cursor settings, checked against an in-bench model of the message and window.
// Depends on ssd_pkg and the scrolling_sixteen_segment_driver RTL.
`timescale 1ns / 100ps

module tb_scrolling_sixteen_segment_driver;

    localparam int MSG_DEPTH   = 128;
    localparam int NUM_DIGITS  = 6;
    localparam int SETTLE_CYC  = 12;
    localparam int NUM_DIR     = 25;
    localparam int NUM_PHASES  = 5;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  digit;
        logic [15:0] seg;
    } digit_drive_t;

    typedef struct packed {
        ssd_pkg::mode_t mode;
        logic [6:0]     code;
        logic           typed;
        logic [2:0]     digit;
        logic [15:0]    seg;
    } stim_row_t;

    localparam logic [15:0] FONT [64] = '{
        16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFF3F, 16'h0000, 16'h0000,
        16'h00F6, 16'hCFF7, 16'h113F, 16'h03BF, 16'hCE3F, 16'h223F, 16'h203F, 16'h3F36,
        16'h003F, 16'h023F, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFDE, 16'h0000,
        16'h0000, 16'h0C3F, 16'h03AD, 16'h30FF, 16'h03ED, 16'h307F, 16'h3C7F, 16'h20BF,
        16'hCC3F, 16'h33ED, 16'hC1FF, 16'hFC73, 16'hF0FF, 16'hCCD7, 16'hCCDB, 16'h00FF,
        16'h1C3F, 16'h00FB, 16'h1C3B, 16'h223F, 16'h3FED, 16'hC0FF, 16'hFCF6, 16'hCCFA,
        16'hFFD2, 16'hFFD5, 16'h33F6, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hF3FF
    };

    // The message below is 0, 127, 'A', '!', '_', ' ', 31, 96 before the first scroll.
    localparam stim_row_t DIRECTED_ROWS [NUM_DIR] = '{
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd0, 16'hFFFF},
        '{ssd_pkg::MODE_REFRESH, 7'd127, 1'b1, 3'd1, 16'hFFFF},
        '{ssd_pkg::MODE_APPEND,  7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd127, 1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd65,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd33,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd95,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd32,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd31,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd96,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_SCROLL,  7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd2, 16'h0C3F},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd3, 16'h0000},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd4, 16'hF3FF},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd5, 16'hFFFF},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b1, 3'd0, 16'hFFFF},
        '{ssd_pkg::MODE_REFRESH, 7'd127, 1'b1, 3'd1, 16'hFFFF},
        '{ssd_pkg::MODE_SCROLL,  7'd127, 1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_CLEAR,   7'd127, 1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_SCROLL,  7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_APPEND,  7'd45,  1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_SCROLL,  7'd0,   1'b0, 3'd0, 16'h0000},
        '{ssd_pkg::MODE_REFRESH, 7'd0,   1'b0, 3'd0, 16'h0000}
    };

    localparam int PH_POS    [NUM_PHASES] = '{0, 5, 7, 3, 6};
    localparam int PH_CHAR   [NUM_PHASES] = '{0, 127, 65, 95, 45};
    localparam int PH_ITEMS  [NUM_PHASES] = '{150, 250, 120, 120, 110};
    localparam int PH_APPEND [NUM_PHASES] = '{30, 60, 20, 25, 30};
    localparam int PH_SCROLL [NUM_PHASES] = '{15, 10, 25, 15, 15};
    localparam int PH_CLEAR  [NUM_PHASES] = '{5, 0, 5, 5, 5};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    logic [6:0]   msg_store [MSG_DEPTH];
    int           msg_len;
    int           scroll_ofs;
    logic [6:0]   window [NUM_DIGITS];
    logic [2:0]   digit_ctr;
    logic [2:0]   cur_pos;
    logic [6:0]   cur_char;
    digit_drive_t pending_drives [$];
    int           err_count;
    bit           snd_quiet;
    bit           rcv_quiet;

    scrolling_sixteen_segment_driver dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] segment_pattern(input logic [6:0] code);
        if (code < 7'd32 || code > 7'd95)
        begin
            return 16'hFFFF;
        end
        return FONT[code - 7'd32];
    endfunction

    task automatic blank_window();
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            window[i] = ssd_pkg::SPACE_CODE;
        end
    endtask

    task automatic predict_request(input ssd_pkg::mode_t mode, input logic [6:0] code,
                                   output bit emits, output digit_drive_t drive);
        logic [6:0] shown;
        emits = 1'b0;
        drive = '0;
        case (mode)
            ssd_pkg::MODE_REFRESH:
            begin
                shown = (cur_pos == digit_ctr) ? cur_char : window[digit_ctr];
                drive.digit = digit_ctr;
                drive.seg = segment_pattern(shown);
                digit_ctr = (digit_ctr == NUM_DIGITS - 1) ? 3'd0 : digit_ctr + 3'd1;
                emits = 1'b1;
            end
            ssd_pkg::MODE_APPEND:
            begin
                if (msg_len < MSG_DEPTH)
                begin
                    msg_store[msg_len] = code;
                    msg_len++;
                end
            end
            ssd_pkg::MODE_SCROLL:
            begin
                if (msg_len == 0)
                begin
                    blank_window();
                    scroll_ofs = 0;
                end
                else
                begin
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        window[i] = (i < msg_len) ? msg_store[(scroll_ofs + i) % msg_len]
                                                  : ssd_pkg::SPACE_CODE;
                    end
                    scroll_ofs = (scroll_ofs + 1) % msg_len;
                end
            end
            default:
            begin
                msg_len = 0;
                scroll_ofs = 0;
                blank_window();
            end
        endcase
    endtask

    task automatic send_request(input stim_row_t row);
        int           gap;
        bit           emits;
        digit_drive_t drive;
        gap = snd_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.mode;
        s_tdata  <= {1'b0, row.code};
        do @(posedge clk); while (!s_tready);
        predict_request(row.mode, row.code, emits, drive);
        if (emits)
        begin
            if (row.typed)
            begin
                drive.digit = row.digit;
                drive.seg = row.seg;
            end
            pending_drives.push_back(drive);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == ssd_pkg::CFG_CURSOR_POS)
        begin
            cur_pos = value[2:0];
        end
        else if (idx == ssd_pkg::CFG_CURSOR_CHAR)
        begin
            cur_char = value;
        end
    endtask

    task automatic configure(input int pos, input int chr, input bit poke_unused);
        if (poke_unused)
        begin
            write_reg(CFG_UNUSED, 7'h7F);
        end
        write_reg(ssd_pkg::CFG_CURSOR_POS, 7'(pos));
        write_reg(ssd_pkg::CFG_CURSOR_CHAR, 7'(chr));
        cfg_valid <= 1'b0;
    endtask

    function automatic stim_row_t random_row(input int ph);
        stim_row_t row;
        int        r;
        row = '0;
        r = $urandom_range(0, 99);
        if (r < PH_CLEAR[ph])
        begin
            row.mode = ssd_pkg::MODE_CLEAR;
        end
        else if (r < PH_CLEAR[ph] + PH_SCROLL[ph])
        begin
            row.mode = ssd_pkg::MODE_SCROLL;
        end
        else if (r < PH_CLEAR[ph] + PH_SCROLL[ph] + PH_APPEND[ph])
        begin
            row.mode = ssd_pkg::MODE_APPEND;
        end
        else
        begin
            row.mode = ssd_pkg::MODE_REFRESH;
        end
        row.code = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 127))
                                             : 7'($urandom_range(32, 95));
        return row;
    endfunction

    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin : stall_results
            int gap;
            if ($urandom_range(0, 31) == 0)
            begin
                rcv_quiet = !rcv_quiet;
            end
            gap = rcv_quiet ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin : check_results
        digit_drive_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                $error("result with no request pending: digit_select %0d segments %h",
                       m_tuser, m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_drives.pop_front();
                if (m_tuser !== want.digit)
                begin
                    $error("digit_select: expected %0d, got %0d", want.digit, m_tuser);
                    err_count++;
                end
                if (m_tdata !== want.seg)
                begin
                    $error("segments: expected %h, got %h", want.seg, m_tdata);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ssd_pkg::MODE_REFRESH;
        cfg_valid = 1'b0;
        cfg_index = ssd_pkg::CFG_CURSOR_POS;
        cfg_data  = '0;
        err_count = 0;
        snd_quiet = 1'b0;
        rcv_quiet = 1'b0;
        cur_pos   = 3'd6;
        cur_char  = ssd_pkg::CURSOR_CHAR_INIT;
        msg_len   = 0;
        scroll_ofs = 0;
        digit_ctr = 3'd0;
        blank_window();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
        begin
            send_request(DIRECTED_ROWS[i]);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            configure(PH_POS[ph], PH_CHAR[ph], ph == 2);
            @(posedge clk);
            for (int n = 0; n < PH_ITEMS[ph]; n++)
            begin
                if ($urandom_range(0, 31) == 0)
                begin
                    snd_quiet = !snd_quiet;
                end
                if ($urandom_range(0, 99) == 0)
                begin
                    wait_drained();
                end
                send_request(random_row(ph));
            end
        end

        wait_drained();
        if (pending_drives.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_drives.size());
            err_count++;
        end
        if (err_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
